### hdl/cbz_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbz_pkg
// Register indexes, opcodes and split point positions shared by the cubic
// Bezier evaluation and split unit.
// ----------------------------------------------------------------------------
package cbz_pkg;

	localparam int NUM_REGS = 8;
	localparam int REG_IDX_WIDTH = 3;
	localparam int POS_WIDTH = 3;

	localparam logic [REG_IDX_WIDTH-1:0] REG_CTRL0_X = 3'd0;
	localparam logic [REG_IDX_WIDTH-1:0] REG_CTRL0_Y = 3'd1;
	localparam logic [REG_IDX_WIDTH-1:0] REG_CTRL1_X = 3'd2;
	localparam logic [REG_IDX_WIDTH-1:0] REG_CTRL1_Y = 3'd3;
	localparam logic [REG_IDX_WIDTH-1:0] REG_CTRL2_X = 3'd4;
	localparam logic [REG_IDX_WIDTH-1:0] REG_CTRL2_Y = 3'd5;
	localparam logic [REG_IDX_WIDTH-1:0] REG_CTRL3_X = 3'd6;
	localparam logic [REG_IDX_WIDTH-1:0] REG_CTRL3_Y = 3'd7;

	localparam logic OP_EVAL  = 1'b0;
	localparam logic OP_SPLIT = 1'b1;

	localparam logic [POS_WIDTH-1:0] POS_P0 = 3'd0;
	localparam logic [POS_WIDTH-1:0] POS_Q0 = 3'd1;
	localparam logic [POS_WIDTH-1:0] POS_R0 = 3'd2;
	localparam logic [POS_WIDTH-1:0] POS_S  = 3'd3;
	localparam logic [POS_WIDTH-1:0] POS_R1 = 3'd4;
	localparam logic [POS_WIDTH-1:0] POS_Q2 = 3'd5;
	localparam logic [POS_WIDTH-1:0] POS_P3 = 3'd6;

endpackage
`default_nettype wire

### hdl/cbz_lerp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbz_lerp
// Two-stage fixed-point interpolation a + floor(t*(b-a) / 2^T_FRAC_BITS).
// The first stage forms the difference and the product, the second adds.
// ----------------------------------------------------------------------------
module cbz_lerp #(
	parameter int COORD_WIDTH = 32,
	parameter int T_FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [COORD_WIDTH-1:0] a,
	input  logic [COORD_WIDTH-1:0] b,
	input  logic [T_FRAC_BITS:0]   t,
	output logic [COORD_WIDTH-1:0] y
);

	localparam int PW = COORD_WIDTH + T_FRAC_BITS + 3;

	logic signed [COORD_WIDTH:0]   diff;
	logic signed [T_FRAC_BITS+1:0] t_ext;
	logic signed [PW-1:0]          prod;
	logic signed [PW-1:0]          prod_s1;
	logic [COORD_WIDTH-1:0]        a_s1;
	logic [COORD_WIDTH-1:0]        y_s2;

	assign diff  = {b[COORD_WIDTH-1], b} - {a[COORD_WIDTH-1], a};
	assign t_ext = {1'b0, t};
	assign prod  = diff * t_ext;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
			a_s1    <= a;
			y_s2    <= a_s1 + prod_s1[T_FRAC_BITS+COORD_WIDTH-1:T_FRAC_BITS];
		end
	end

	assign y = y_s2;

endmodule
`default_nettype wire

### hdl/cubic_bezier_casteljau_eval_split.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bezier_casteljau_eval_split
// Cubic Bezier evaluation and subdivision by de Casteljau levels in fixed
// point, with control points held in configuration registers.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_*       in         tdata: param_t; tuser: opcode
//  m_*       out        tdata: point_x, point_y, tangent_x, tangent_y;
//                       tuser: point_index; tlast: last
//  cfg_*     in         write enable, register index, register value
//
// An evaluate request yields one result and a split request seven results in
// turn, during which the input stalls; the seven-entry output sequencer sets
// that figure. A request passes through stages s1 to s7 before its result is
// registered at the output.
// Reset clears the control points to zero and empties the pipeline.
// A stall at the output freezes every stage once s7 holds a request, so nothing is lost.
// ----------------------------------------------------------------------------
module cubic_bezier_casteljau_eval_split
	import cbz_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int T_FRAC_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// param_t
	input  logic [((T_FRAC_BITS+1+7)/8)*8-1:0]       s_tdata,
	// opcode
	input  logic                                     s_tuser,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// point_x, point_y, tangent_x, tangent_y
	output logic [((4*COORD_WIDTH+8+7)/8)*8-1:0]     m_tdata,
	// point_index
	output logic [POS_WIDTH-1:0]                     m_tuser,
	output logic                                     m_tlast,
	input  logic                                     cfg_we,
	input  logic [REG_IDX_WIDTH-1:0]                 cfg_index,
	input  logic [COORD_WIDTH-1:0]                   cfg_data
);

	localparam int W   = COORD_WIDTH;
	localparam int TW  = T_FRAC_BITS + 1;
	localparam int TGW = COORD_WIDTH + 4;
	localparam int ODW = ((4*COORD_WIDTH+8+7)/8)*8;
	localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

	logic [W-1:0] ctrl_q [NUM_REGS];

	logic adv, take, out_free, is_last;
	logic [TW-1:0] t_in;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic op_s1, op_s2, op_s3, op_s4, op_s5, op_s6, op_s7;
	logic [TW-1:0] t_s1, t_s2, t_s3, t_s4, t_s5;

	logic [W-1:0] p [4][2];
	logic [W-1:0] q_s3 [3][2];
	logic [W-1:0] r_s5 [2][2];
	logic [W-1:0] s_s7 [2];
	logic [W-1:0] q0_s4 [2], q0_s5 [2], q0_s6 [2], q0_s7 [2];
	logic [W-1:0] q2_s4 [2], q2_s5 [2], q2_s6 [2], q2_s7 [2];
	logic [W-1:0] r0_s6 [2], r0_s7 [2], r1_s6 [2], r1_s7 [2];
	logic [W:0]   dr [2];
	logic [TGW-1:0] tan [2];
	logic [TGW-1:0] tan_s6 [2], tan_s7 [2];

	logic [POS_WIDTH-1:0] idx_q;
	logic m_tvalid_q, m_tlast_q;
	logic [POS_WIDTH-1:0] m_tuser_q;
	logic [W-1:0] px_q, py_q;
	logic [TGW-1:0] tx_q, ty_q;
	logic [W-1:0] sel_x, sel_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				ctrl_q[i] <= '0;
			end
		end else if (cfg_we) begin
			ctrl_q[cfg_index] <= cfg_data;
		end
	end

	assign p[0][0] = ctrl_q[REG_CTRL0_X];
	assign p[0][1] = ctrl_q[REG_CTRL0_Y];
	assign p[1][0] = ctrl_q[REG_CTRL1_X];
	assign p[1][1] = ctrl_q[REG_CTRL1_Y];
	assign p[2][0] = ctrl_q[REG_CTRL2_X];
	assign p[2][1] = ctrl_q[REG_CTRL2_Y];
	assign p[3][0] = ctrl_q[REG_CTRL3_X];
	assign p[3][1] = ctrl_q[REG_CTRL3_Y];

	assign out_free = !m_tvalid_q || m_tready;
	assign take     = valid_s7 && out_free;
	assign is_last  = (op_s7 == OP_EVAL) || (idx_q == POS_P3);
	assign adv      = !valid_s7 || (take && is_last);
	assign s_tready = adv;

	assign t_in = s_tdata[TW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= s_tuser;
			t_s1  <= (t_in > T_ONE) ? T_ONE : t_in;
			op_s2 <= op_s1;
			t_s2  <= t_s1;
			op_s3 <= op_s2;
			t_s3  <= t_s2;
			op_s4 <= op_s3;
			t_s4  <= t_s3;
			op_s5 <= op_s4;
			t_s5  <= t_s4;
			op_s6 <= op_s5;
			op_s7 <= op_s6;
			for (int c = 0; c < 2; c++) begin
				q0_s4[c]  <= q_s3[0][c];
				q2_s4[c]  <= q_s3[2][c];
				q0_s5[c]  <= q0_s4[c];
				q2_s5[c]  <= q2_s4[c];
				q0_s6[c]  <= q0_s5[c];
				q2_s6[c]  <= q2_s5[c];
				q0_s7[c]  <= q0_s6[c];
				q2_s7[c]  <= q2_s6[c];
				r0_s6[c]  <= r_s5[0][c];
				r1_s6[c]  <= r_s5[1][c];
				r0_s7[c]  <= r0_s6[c];
				r1_s7[c]  <= r1_s6[c];
				tan_s6[c] <= tan[c];
				tan_s7[c] <= tan_s6[c];
			end
		end
	end

	for (genvar c = 0; c < 2; c++) begin : g_coord
		for (genvar i = 0; i < 3; i++) begin : g_q
			cbz_lerp #(.COORD_WIDTH(W), .T_FRAC_BITS(T_FRAC_BITS)) u_q (
				.clk (clk),
				.en  (adv),
				.a   (p[i][c]),
				.b   (p[i+1][c]),
				.t   (t_s1),
				.y   (q_s3[i][c])
			);
		end
		for (genvar i = 0; i < 2; i++) begin : g_r
			cbz_lerp #(.COORD_WIDTH(W), .T_FRAC_BITS(T_FRAC_BITS)) u_r (
				.clk (clk),
				.en  (adv),
				.a   (q_s3[i][c]),
				.b   (q_s3[i+1][c]),
				.t   (t_s3),
				.y   (r_s5[i][c])
			);
		end
		cbz_lerp #(.COORD_WIDTH(W), .T_FRAC_BITS(T_FRAC_BITS)) u_s (
			.clk (clk),
			.en  (adv),
			.a   (r_s5[0][c]),
			.b   (r_s5[1][c]),
			.t   (t_s5),
			.y   (s_s7[c])
		);

		// Three times the difference, as a shift and an add.
		assign dr[c]  = {r_s5[1][c][W-1], r_s5[1][c]} - {r_s5[0][c][W-1], r_s5[0][c]};
		assign tan[c] = {{3{dr[c][W]}}, dr[c]} + {{2{dr[c][W]}}, dr[c], 1'b0};
	end

	always_comb begin
		case (idx_q)
			POS_P0: begin
				sel_x = p[0][0];
				sel_y = p[0][1];
			end
			POS_Q0: begin
				sel_x = q0_s7[0];
				sel_y = q0_s7[1];
			end
			POS_R0: begin
				sel_x = r0_s7[0];
				sel_y = r0_s7[1];
			end
			POS_S: begin
				sel_x = s_s7[0];
				sel_y = s_s7[1];
			end
			POS_R1: begin
				sel_x = r1_s7[0];
				sel_y = r1_s7[1];
			end
			POS_Q2: begin
				sel_x = q2_s7[0];
				sel_y = q2_s7[1];
			end
			POS_P3: begin
				sel_x = p[3][0];
				sel_y = p[3][1];
			end
			default: begin
				sel_x = p[0][0];
				sel_y = p[0][1];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tlast_q  <= 1'b0;
			m_tuser_q  <= POS_P0;
			idx_q      <= POS_P0;
		end else begin
			if (out_free) begin
				m_tvalid_q <= valid_s7;
			end
			if (take) begin
				m_tlast_q <= is_last;
				m_tuser_q <= (op_s7 == OP_EVAL) ? POS_P0 : idx_q;
				idx_q     <= is_last ? POS_P0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (op_s7 == OP_EVAL) begin
				px_q <= s_s7[0];
				py_q <= s_s7[1];
				tx_q <= tan_s7[0];
				ty_q <= tan_s7[1];
			end else begin
				px_q <= sel_x;
				py_q <= sel_y;
				tx_q <= '0;
				ty_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = {{(ODW-4*COORD_WIDTH-8){1'b0}}, ty_q, tx_q, py_q, px_q};

	a_eval_single : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s7 && op_s7 == OP_EVAL) |-> idx_q == POS_P0)
		else $error("evaluate request found mid-sequence in the sequencer");

	a_idx_range : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s7 |-> idx_q <= POS_P3)
		else $error("split position ran past the last point");

	a_split_order : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
			(m_tvalid && m_tuser == $past(m_tuser) + 3'd1))
		else $error("split results not delivered back to back in order");

	a_no_accept_mid_split : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s7 && !is_last) |-> !s_tready)
		else $error("input accepted while a split sequence is still running");

endmodule
`default_nettype wire
